// File: rtl/core/ilst_pkg.sv
package ilst_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OP_W     = 3;
    localparam int POS_W    = 7;
    localparam int ST_W     = 2;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT     = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd4;
    localparam logic [OP_W-1:0] OP_ERASE      = 3'd5;
    localparam logic [OP_W-1:0] OP_READ       = 3'd6;

    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } ram_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [POS_W-1:0]  length;
        logic [ST_W-1:0]   status;
    } res_t;

endpackage

// File: rtl/core/indexed_list_engine.sv
// Flow: pops at the back and rejected items go from the check state to the result; reads pass
// through a read-wait state; insert, push, erase and pop at the front go through a shift state
// that moves the entries one by one, then a finish state that updates the length.
// Throughput: one item at a time; the next item is taken in the cycle after the result moved to
// the output register. Entry moves use one memory read and one memory write per cycle.
// Reset: aresetn low clears the length to zero and the control state; list memory is kept.
module indexed_list_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // position[6:0], value_in[38:7], zero pad
    input  logic [2:0]  s_axis_tuser,   // op[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // value_out[31:0], length[38:32], zero pad
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    ilst_pkg::ram_req_t          ram_req;
    logic [ilst_pkg::DATA_W-1:0] ram_rd_data;
    ilst_pkg::res_t              res;
    logic                        res_valid;
    logic                        res_ready;

    logic                        m_valid_reg, m_valid_next;
    ilst_pkg::res_t              m_res_reg, m_res_next;

    ilst_ram u_ram (
        .aclk    (aclk),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    ilst_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_op       (s_axis_tuser),
        .in_pos      (s_axis_tdata[6:0]),
        .in_value    (s_axis_tdata[38:7]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .ram_req     (ram_req),
        .ram_rd_data (ram_rd_data)
    );

    assign res_ready = !m_valid_reg || m_axis_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, m_res_reg.length, m_res_reg.value};
    assign m_axis_tuser  = m_res_reg.status;

`ifndef SYNTHESIS
    a_full_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == ilst_pkg::ST_FULL)
        |-> (m_axis_tdata[38:32] == 7'(ilst_pkg::CAPACITY)))
        else $error("full status with length below capacity");

    a_empty_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == ilst_pkg::ST_EMPTY)
        |-> (m_axis_tdata[38:32] == 7'd0))
        else $error("empty status with nonzero length");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[38:32] <= 7'(ilst_pkg::CAPACITY)))
        else $error("length beyond capacity");

    a_read_only_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser != ilst_pkg::ST_DONE)
        |-> (m_axis_tdata[31:0] == 32'd0))
        else $error("value returned on a rejected item");
`endif

endmodule

// File: rtl/core/ilst_ram.sv
module ilst_ram (
    input  logic                           aclk,
    input  ilst_pkg::ram_req_t             req,
    output logic [ilst_pkg::DATA_W-1:0]    rd_data
);

    logic [ilst_pkg::DATA_W-1:0] mem [ilst_pkg::CAPACITY];
    logic [ilst_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/ilst_seq.sv
module ilst_seq (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ilst_pkg::OP_W-1:0]      in_op,
    input  logic [ilst_pkg::POS_W-1:0]     in_pos,
    input  logic [ilst_pkg::DATA_W-1:0]    in_value,
    output logic                           res_valid,
    input  logic                           res_ready,
    output ilst_pkg::res_t                 res,
    output ilst_pkg::ram_req_t             ram_req,
    input  logic [ilst_pkg::DATA_W-1:0]    ram_rd_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_FINISH = 3'd3;
    localparam logic [2:0] S_RDW    = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    localparam logic [ilst_pkg::CNT_W-1:0] CNT_FULL = ilst_pkg::CNT_W'(ilst_pkg::CAPACITY);
    localparam logic [ilst_pkg::CNT_W-1:0] CNT_ONE  = ilst_pkg::CNT_W'(1);

    logic [2:0]                     state_reg, state_next;
    logic [ilst_pkg::OP_W-1:0]      op_reg, op_next;
    logic [ilst_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [ilst_pkg::DATA_W-1:0]    val_reg, val_next;
    logic [ilst_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [ilst_pkg::CNT_W-1:0]     cur_reg, cur_next;
    logic [ilst_pkg::CNT_W-1:0]     rem_reg, rem_next;
    logic [ilst_pkg::CNT_W-1:0]     place_reg, place_next;
    logic                           ins_reg, ins_next;
    logic                           pend_vld_reg, pend_vld_next;
    logic [ilst_pkg::IDX_W-1:0]     pend_addr_reg, pend_addr_next;
    logic [ilst_pkg::ST_W-1:0]      st_reg, st_next;
    logic [ilst_pkg::DATA_W-1:0]    rd_val_reg, rd_val_next;

    logic                           full;
    logic                           empty;
    logic [ilst_pkg::CNT_W-1:0]     pos_c;
    logic [ilst_pkg::CNT_W-1:0]     ins_place;
    logic [ilst_pkg::CNT_W-1:0]     dest;

    assign full  = (cnt_reg == CNT_FULL);
    assign empty = (cnt_reg == '0);
    assign pos_c = ilst_pkg::CNT_W'(pos_reg);
    assign dest  = ins_reg ? (cur_reg + CNT_ONE) : (cur_reg - CNT_ONE);

    always_comb begin
        unique case (op_reg)
            ilst_pkg::OP_PUSH_FRONT: ins_place = '0;
            ilst_pkg::OP_PUSH_BACK:  ins_place = cnt_reg;
            default:                 ins_place = pos_c;
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        cnt_next       = cnt_reg;
        cur_next       = cur_reg;
        rem_next       = rem_reg;
        place_next     = place_reg;
        ins_next       = ins_reg;
        pend_vld_next  = pend_vld_reg;
        pend_addr_next = pend_addr_reg;
        st_next        = st_reg;
        rd_val_next    = rd_val_reg;
        ram_req        = '0;
        in_ready       = 1'b0;
        res_valid      = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op_next     = in_op;
                    pos_next    = in_pos;
                    val_next    = in_value;
                    st_next     = ilst_pkg::ST_DONE;
                    rd_val_next = '0;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                pend_vld_next = 1'b0;
                state_next    = S_DONE;
                unique case (op_reg)
                    ilst_pkg::OP_PUSH_FRONT, ilst_pkg::OP_PUSH_BACK,
                    ilst_pkg::OP_INSERT: begin
                        if (full) begin
                            st_next = ilst_pkg::ST_FULL;
                        end else if (op_reg == ilst_pkg::OP_INSERT && pos_c > cnt_reg) begin
                            st_next = ilst_pkg::ST_RANGE;
                        end else begin
                            ins_next   = 1'b1;
                            place_next = ins_place;
                            rem_next   = cnt_reg - ins_place;
                            cur_next   = cnt_reg - CNT_ONE;
                            state_next = S_SHIFT;
                        end
                    end
                    ilst_pkg::OP_POP_FRONT: begin
                        if (empty) begin
                            st_next = ilst_pkg::ST_EMPTY;
                        end else begin
                            ins_next   = 1'b0;
                            place_next = '0;
                            rem_next   = cnt_reg - CNT_ONE;
                            cur_next   = CNT_ONE;
                            state_next = S_SHIFT;
                        end
                    end
                    ilst_pkg::OP_POP_BACK: begin
                        if (empty) begin
                            st_next = ilst_pkg::ST_EMPTY;
                        end else begin
                            cnt_next = cnt_reg - CNT_ONE;
                        end
                    end
                    ilst_pkg::OP_ERASE: begin
                        if (pos_c >= cnt_reg) begin
                            st_next = ilst_pkg::ST_RANGE;
                        end else begin
                            ins_next   = 1'b0;
                            place_next = pos_c;
                            rem_next   = cnt_reg - CNT_ONE - pos_c;
                            cur_next   = pos_c + CNT_ONE;
                            state_next = S_SHIFT;
                        end
                    end
                    ilst_pkg::OP_READ: begin
                        if (pos_c >= cnt_reg) begin
                            st_next = ilst_pkg::ST_RANGE;
                        end else begin
                            ram_req.re    = 1'b1;
                            ram_req.raddr = pos_reg[ilst_pkg::IDX_W-1:0];
                            state_next    = S_RDW;
                        end
                    end
                    default: begin
                        st_next = ilst_pkg::ST_DONE;
                    end
                endcase
            end
            S_SHIFT: begin
                if (pend_vld_reg) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = pend_addr_reg;
                    ram_req.wdata = ram_rd_data;
                end
                if (rem_reg != '0) begin
                    ram_req.re     = 1'b1;
                    ram_req.raddr  = cur_reg[ilst_pkg::IDX_W-1:0];
                    pend_vld_next  = 1'b1;
                    pend_addr_next = dest[ilst_pkg::IDX_W-1:0];
                    cur_next       = ins_reg ? (cur_reg - CNT_ONE) : (cur_reg + CNT_ONE);
                    rem_next       = rem_reg - CNT_ONE;
                end else begin
                    pend_vld_next = 1'b0;
                    if (!pend_vld_reg) begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                if (ins_reg) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = place_reg[ilst_pkg::IDX_W-1:0];
                    ram_req.wdata = val_reg;
                    cnt_next      = cnt_reg + CNT_ONE;
                end else begin
                    cnt_next      = cnt_reg - CNT_ONE;
                end
                state_next = S_DONE;
            end
            S_RDW: begin
                rd_val_next = ram_rd_data;
                state_next  = S_DONE;
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            pend_vld_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            pend_vld_reg <= pend_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        cur_reg       <= cur_next;
        rem_reg       <= rem_next;
        place_reg     <= place_next;
        ins_reg       <= ins_next;
        pend_addr_reg <= pend_addr_next;
        st_reg        <= st_next;
        rd_val_reg    <= rd_val_next;
    end

    assign res.value  = rd_val_reg;
    assign res.length = ilst_pkg::POS_W'(cnt_reg);
    assign res.status = st_reg;

endmodule
